// ===== hdl/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg
// shared types and codes for the gtp-u downlink tunnel table classifier
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int MODE_W    = 2;
  localparam int VERDICT_W = 3;
  localparam int ADDR_W    = 32;
  localparam int TEID_W    = 32;
  localparam int VER_W     = 4;
  localparam int LEN_W     = 16;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  // operation selector on the input stream
  localparam mode_t MODE_LOOKUP   = 2'd0;
  localparam mode_t MODE_MODIFY   = 2'd1;
  localparam mode_t MODE_DEL_USER = 2'd2;
  localparam mode_t MODE_DEL_CTRL = 2'd3;

  // result codes
  localparam verdict_t V_UNKNOWN  = 3'd0;
  localparam verdict_t V_FORWARD  = 3'd1;
  localparam verdict_t V_NOTIFY   = 3'd2;
  localparam verdict_t V_NOCTRL   = 3'd3;
  localparam verdict_t V_BADHDR   = 3'd4;
  localparam verdict_t V_OK       = 3'd5;
  localparam verdict_t V_NOTFOUND = 3'd6;
  localparam verdict_t V_FULL     = 3'd7;

  // ip header sanity limits
  localparam logic [VER_W-1:0] IP_VERSION_V4    = 4'd4;
  localparam logic [LEN_W-1:0] MIN_IP_TOTAL_LEN = 16'd20;

  // tunnel payload word held in the ram, enb_ip in the low bits
  localparam int PAYLOAD_W = ADDR_W + TEID_W + TEID_W;

  // decision handed from the table to the pipeline
  typedef struct packed {
    verdict_t verdict;
    logic     ram_wr;
  } tbl_resp_t;

endpackage

// ===== hdl/gtc_ram.sv =====
// ----------------------------------------------------------------------------
// gtc_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gtc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/gtc_table.sv =====
// ----------------------------------------------------------------------------
// gtc_table
// key cam with user and control valid marks, match, free search and decision
// ----------------------------------------------------------------------------
module gtc_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  gtc_pkg::mode_t               mode,
  input  logic [gtc_pkg::ADDR_W-1:0]   key,
  input  logic                         hdr_ok,
  output gtc_pkg::tbl_resp_t           resp,
  output logic [IDX_W-1:0]             idx
);

  import gtc_pkg::*;

  logic [ADDR_W-1:0]        entry_key [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] user_valid;
  logic [TABLE_ENTRIES-1:0] ctrl_valid;

  logic [TABLE_ENTRIES-1:0] in_use;
  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic                     hit_user;
  logic                     hit_ctrl;
  logic                     any_free;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;

  assign in_use = user_valid | ctrl_valid;

  // keys are unique among entries in use, so the match vector is one-hot
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = in_use[i] && (entry_key[i] == key);
      hit_idx  = hit_idx | (match[i] ? IDX_W'(i) : '0);
    end
  end

  assign hit      = |match;
  assign hit_user = |(match & user_valid);
  assign hit_ctrl = |(match & ctrl_valid);
  assign any_free = ~&in_use;

  // lowest-numbered free entry
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign idx = hit ? hit_idx : free_idx;

  always_comb begin
    resp.ram_wr = 1'b0;
    case (mode)
      MODE_LOOKUP: begin
        if (!hdr_ok) begin
          resp.verdict = V_BADHDR;
        end else if (!hit) begin
          resp.verdict = V_UNKNOWN;
        end else if (hit_user && hit_ctrl) begin
          resp.verdict = V_FORWARD;
        end else if (hit_ctrl) begin
          resp.verdict = V_NOTIFY;
        end else begin
          resp.verdict = V_NOCTRL;
        end
      end
      MODE_MODIFY: begin
        if (hit || any_free) begin
          resp.verdict = V_OK;
          resp.ram_wr  = 1'b1;
        end else begin
          resp.verdict = V_FULL;
        end
      end
      MODE_DEL_USER: resp.verdict = hit_user ? V_OK : V_NOTFOUND;
      MODE_DEL_CTRL: resp.verdict = hit_ctrl ? V_OK : V_NOTFOUND;
      default:       resp.verdict = V_NOTFOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_valid <= '0;
      ctrl_valid <= '0;
    end else if (en) begin
      case (mode)
        MODE_MODIFY: begin
          if (resp.ram_wr) begin
            user_valid[idx] <= 1'b1;
            ctrl_valid[idx] <= 1'b1;
          end
        end
        MODE_DEL_USER: begin
          if (hit_user) begin
            user_valid[hit_idx] <= 1'b0;
          end
        end
        MODE_DEL_CTRL: begin
          if (hit_ctrl) begin
            ctrl_valid[hit_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en && resp.ram_wr) begin
      entry_key[idx] <= key;
    end
  end

endmodule

// ===== hdl/gtp_tunnel_table_classifier.sv =====
// ----------------------------------------------------------------------------
// gtp_tunnel_table_classifier
// downlink gtp-u tunnel lookup and tunnel table maintenance
// ----------------------------------------------------------------------------
// usage
//   s_* carries one command per transfer: s_tuser holds the mode (lookup,
//   modify, delete user tunnel, delete control tunnel), s_tdata the ue key,
//   tunnel fields and ip header fields. every command gives exactly one
//   result transfer on m_*: m_tuser is the verdict, m_tdata the forwarding
//   fields (zero where the verdict does not name them).
//   results are registered through stage a, stage b and the output register.
//   throughput: one command per cycle unless m_tready stalls; the key cam
//   compares all entries at once and updates its valid marks on the clock edge,
//   and the tunnel payload ram takes one write and one read per cycle.
//   commands are applied in order, so a lookup right after a modify of the
//   same key already sees the new tunnel.
//   reset clears all valid marks (empty table) and the pipeline; payload
//   ram and key registers are not cleared, entries are used only once set.
//   when m_tready is low the result is held and the pipeline fills; s_tready
//   drops only once every stage holds a command.
// ----------------------------------------------------------------------------
module gtp_tunnel_table_classifier #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ue_ip[31:0], enb_ip[63:32], enb_teid[95:64], ctrl_teid[127:96],
  // ip_version[131:128], ip_total_length[147:132], packet_bytes[163:148],
  // zero fill [167:164]
  input  logic [167:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_enb_ip[31:0], out_enb_teid[63:32], out_ctrl_teid[95:64],
  // out_length[111:96]
  output logic [111:0] m_tdata,
  // verdict[2:0]
  output logic [2:0]   m_tuser
);

  import gtc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // stage a: registered command
  logic               a_valid;
  mode_t              a_mode;
  logic [ADDR_W-1:0]  a_ue_ip;
  logic [ADDR_W-1:0]  a_enb_ip;
  logic [TEID_W-1:0]  a_enb_teid;
  logic [TEID_W-1:0]  a_ctrl_teid;
  logic [VER_W-1:0]   a_version;
  logic [LEN_W-1:0]   a_total_len;
  logic [LEN_W-1:0]   a_bytes;

  // stage b: verdict known, payload ram read in flight
  logic               b_valid;
  verdict_t           b_verdict;
  logic [LEN_W-1:0]   b_bytes;

  // output register
  logic               o_valid;
  verdict_t           o_verdict;
  logic [ADDR_W-1:0]  o_enb_ip;
  logic [TEID_W-1:0]  o_enb_teid;
  logic [TEID_W-1:0]  o_ctrl_teid;
  logic [LEN_W-1:0]   o_length;

  logic               o_free;
  logic               b_adv;
  logic               b_free;
  logic               a_adv;
  logic               a_free;
  logic               hdr_ok;
  tbl_resp_t          resp;
  logic [IDX_W-1:0]   idx;
  logic [PAYLOAD_W-1:0] rd_data;
  logic               fwd;
  logic               notify;

  // flow control, each stage moves when the one after it is free
  assign o_free   = !o_valid || m_tready;
  assign b_adv    = b_valid && o_free;
  assign b_free   = !b_valid || o_free;
  assign a_adv    = a_valid && b_free;
  assign a_free   = !a_valid || b_free;
  assign s_tready = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= s_tvalid;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (s_tvalid && a_free) begin
      a_mode      <= s_tuser;
      a_ue_ip     <= s_tdata[31:0];
      a_enb_ip    <= s_tdata[63:32];
      a_enb_teid  <= s_tdata[95:64];
      a_ctrl_teid <= s_tdata[127:96];
      a_version   <= s_tdata[131:128];
      a_total_len <= s_tdata[147:132];
      a_bytes     <= s_tdata[163:148];
    end
  end

  // ip header check, the table is searched regardless but the verdict wins
  assign hdr_ok = (a_version == IP_VERSION_V4) && (a_total_len >= MIN_IP_TOTAL_LEN);

  gtc_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .en     (a_adv),
    .mode   (a_mode),
    .key    (a_ue_ip),
    .hdr_ok (hdr_ok),
    .resp   (resp),
    .idx    (idx)
  );

  // tunnel payload: modify writes, every command reads the indexed entry (the hit entry, else the free one)
  gtc_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_payload (
    .clk     (clk),
    .wr_en   (a_adv && resp.ram_wr),
    .wr_addr (idx),
    .wr_data ({a_ctrl_teid, a_enb_teid, a_enb_ip}),
    .rd_en   (a_adv),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_verdict <= resp.verdict;
      b_bytes   <= a_bytes;
    end
  end

  // result assembly, unused fields are forced to zero
  assign fwd    = (b_verdict == V_FORWARD);
  assign notify = (b_verdict == V_NOTIFY);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= b_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_verdict   <= b_verdict;
      o_enb_ip    <= fwd ? rd_data[ADDR_W-1:0] : '0;
      o_enb_teid  <= fwd ? rd_data[ADDR_W+TEID_W-1:ADDR_W] : '0;
      o_ctrl_teid <= notify ? rd_data[PAYLOAD_W-1:ADDR_W+TEID_W] : '0;
      o_length    <= fwd ? b_bytes : '0;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_verdict;
  assign m_tdata  = {o_length, o_ctrl_teid, o_enb_teid, o_enb_ip};

  // every command leaving stage a lands in stage b
  assert property (@(posedge clk) disable iff (rst) a_adv |=> b_valid)
    else $error("command lost between stage a and stage b");

  // a blocked stage b keeps its verdict, the ram read data is held with it
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_adv |=> b_valid && $stable(b_verdict) && $stable(b_bytes))
    else $error("stage b changed while stalled");

  // a lookup only ever yields one of the lookup verdicts
  assert property (@(posedge clk) disable iff (rst)
    a_adv && a_mode == MODE_LOOKUP |->
      resp.verdict == V_UNKNOWN || resp.verdict == V_FORWARD ||
      resp.verdict == V_NOTIFY || resp.verdict == V_NOCTRL ||
      resp.verdict == V_BADHDR)
    else $error("lookup produced a maintenance verdict");

  // forwarding fields are only populated on a forward verdict
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_verdict != V_FORWARD |->
      o_enb_ip == '0 && o_enb_teid == '0 && o_length == '0)
    else $error("forwarding fields set without a forward verdict");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gtp tunnel table classifier testbench
// drives lookup, modify and delete commands into the tunnel table and checks
// every verdict and forwarding field against a local model of the table
// ----------------------------------------------------------------------------
module testbench;
  import gtc_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_POOL      = 20;   // more keys than entries, so the table fills
  localparam int RANDOM_CMDS   = 1200;
  localparam int STALL_LIMIT   = 2000; // cycles without any transfer

  // s_tdata layout, members listed from the high bits down, ue_ip in the low bits
  typedef struct packed {
    logic [3:0]        fill;
    logic [LEN_W-1:0]  packet_bytes;
    logic [LEN_W-1:0]  ip_total_length;
    logic [VER_W-1:0]  ip_version;
    logic [TEID_W-1:0] ctrl_teid;
    logic [TEID_W-1:0] enb_teid;
    logic [ADDR_W-1:0] enb_ip;
    logic [ADDR_W-1:0] ue_ip;
  } command_word_t;

  // m_tdata layout
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [TEID_W-1:0] ctrl_teid;
    logic [TEID_W-1:0] enb_teid;
    logic [ADDR_W-1:0] enb_ip;
  } forward_word_t;

  typedef struct packed {
    verdict_t      verdict;
    forward_word_t fwd;
  } tunnel_verdict_t;

  // --------------------------------------------------------------------------
  // tunnel table model and verdict checker
  // --------------------------------------------------------------------------
  class tunnel_scoreboard;
    logic [ADDR_W-1:0] key      [TABLE_ENTRIES];
    logic              user_on  [TABLE_ENTRIES];
    logic              ctrl_on  [TABLE_ENTRIES];
    logic [ADDR_W-1:0] enb_ip   [TABLE_ENTRIES];
    logic [TEID_W-1:0] enb_teid [TABLE_ENTRIES];
    logic [TEID_W-1:0] ctrl_teid[TABLE_ENTRIES];
    tunnel_verdict_t   awaited_verdicts[$];
    int                errors;
    int                commands;
    int                results;
    int                verdict_seen[8];

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        user_on[i] = 1'b0;
        ctrl_on[i] = 1'b0;
      end
      errors   = 0;
      commands = 0;
      results  = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
    endfunction

    function int find_key(logic [ADDR_W-1:0] ue);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if ((user_on[i] || ctrl_on[i]) && key[i] == ue) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!user_on[i] && !ctrl_on[i]) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (user_on[i] || ctrl_on[i]) n++;
      return n;
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction

    // apply one accepted command to the table and queue its verdict
    function void note_command(mode_t mode, command_word_t c);
      tunnel_verdict_t r;
      int              idx;
      r   = '0;
      idx = find_key(c.ue_ip);
      case (mode)
        MODE_LOOKUP: begin
          if (c.ip_version != IP_VERSION_V4 || c.ip_total_length < MIN_IP_TOTAL_LEN) begin
            r.verdict = V_BADHDR;
          end else if (idx < 0) begin
            r.verdict = V_UNKNOWN;
          end else if (user_on[idx] && ctrl_on[idx]) begin
            r.verdict      = V_FORWARD;
            r.fwd.enb_ip   = enb_ip[idx];
            r.fwd.enb_teid = enb_teid[idx];
            r.fwd.length   = c.packet_bytes;
          end else if (ctrl_on[idx]) begin
            r.verdict       = V_NOTIFY;
            r.fwd.ctrl_teid = ctrl_teid[idx];
          end else begin
            r.verdict = V_NOCTRL;
          end
        end
        MODE_MODIFY: begin
          if (idx < 0) idx = find_free();
          if (idx < 0) begin
            r.verdict = V_FULL;
          end else begin
            key[idx]       = c.ue_ip;
            enb_ip[idx]    = c.enb_ip;
            enb_teid[idx]  = c.enb_teid;
            ctrl_teid[idx] = c.ctrl_teid;
            user_on[idx]   = 1'b1;
            ctrl_on[idx]   = 1'b1;
            r.verdict      = V_OK;
          end
        end
        MODE_DEL_USER: begin
          if (idx >= 0 && user_on[idx]) begin
            user_on[idx] = 1'b0;
            r.verdict    = V_OK;
          end else begin
            r.verdict = V_NOTFOUND;
          end
        end
        default: begin
          if (idx >= 0 && ctrl_on[idx]) begin
            ctrl_on[idx] = 1'b0;
            r.verdict    = V_OK;
          end else begin
            r.verdict = V_NOTFOUND;
          end
        end
      endcase
      awaited_verdicts.push_back(r);
      commands++;
    endfunction

    function void check_result(verdict_t verdict, forward_word_t fwd);
      tunnel_verdict_t want;
      results++;
      verdict_seen[verdict]++;
      if (awaited_verdicts.size() == 0) begin
        $error("result with no command outstanding: verdict %0d", verdict);
        errors++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
        errors++;
      end
      if (fwd.enb_ip !== want.fwd.enb_ip) begin
        $error("out_enb_ip: expected %h, actual %h", want.fwd.enb_ip, fwd.enb_ip);
        errors++;
      end
      if (fwd.enb_teid !== want.fwd.enb_teid) begin
        $error("out_enb_teid: expected %h, actual %h", want.fwd.enb_teid, fwd.enb_teid);
        errors++;
      end
      if (fwd.ctrl_teid !== want.fwd.ctrl_teid) begin
        $error("out_ctrl_teid: expected %h, actual %h", want.fwd.ctrl_teid, fwd.ctrl_teid);
        errors++;
      end
      if (fwd.length !== want.fwd.length) begin
        $error("out_length: expected %h, actual %h", want.fwd.length, fwd.length);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic          clk = 1'b0;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [167:0]  s_tdata;   // ue_ip, enb_ip, enb_teid, ctrl_teid, ip_version,
                            // ip_total_length, packet_bytes, zero fill
  logic [1:0]    s_tuser;   // mode
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [111:0]  m_tdata;   // out_enb_ip, out_enb_teid, out_ctrl_teid, out_length
  logic [2:0]    m_tuser;   // verdict

  tunnel_scoreboard sb = new();

  logic [ADDR_W-1:0] key_pool[KEY_POOL];
  int                burst_left = 0;
  int                idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gtp_tunnel_table_classifier #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // --------------------------------------------------------------------------
  // monitors: every command transfer feeds the model, every result transfer
  // is checked against the oldest awaited verdict
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_command(mode_t'(s_tuser), command_word_t'(s_tdata));
    if (!rst && m_tvalid && m_tready) sb.check_result(verdict_t'(m_tuser), forward_word_t'(m_tdata));
  end

  // receiver back-pressure: whenever the style counter runs out, switch at random between always ready,
  // random ready and long on/off runs
  int rx_style = 0;
  int rx_style_left = 0;
  int rx_run_left = 0;

  always @(posedge clk) begin
    if (rx_style_left == 0) begin
      rx_style      <= $urandom_range(0, 2);
      rx_style_left <= 150;
    end else begin
      rx_style_left <= rx_style_left - 1;
    end
    case (rx_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_run_left == 0) begin
          m_tready    <= !m_tready;
          rx_run_left <= m_tready ? $urandom_range(1, 12) : $urandom_range(1, 8);
        end else begin
          rx_run_left <= rx_run_left - 1;
        end
      end
    endcase
  end

  // watchdog: a hang shows up as a long run of cycles with no transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic command_word_t make_command(logic [ADDR_W-1:0] ue, logic [ADDR_W-1:0] eip,
                                                 logic [TEID_W-1:0] eteid,
                                                 logic [TEID_W-1:0] cteid,
                                                 logic [VER_W-1:0] ver, logic [LEN_W-1:0] tlen,
                                                 logic [LEN_W-1:0] nbytes);
    command_word_t c;
    c.fill            = '0;
    c.ue_ip           = ue;
    c.enb_ip          = eip;
    c.enb_teid        = eteid;
    c.ctrl_teid       = cteid;
    c.ip_version      = ver;
    c.ip_total_length = tlen;
    c.packet_bytes    = nbytes;
    return c;
  endfunction

  // sender: bursts of back-to-back commands separated by random gaps
  task automatic send_command(input mode_t mode, input command_word_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the sender until every verdict has come back; wait on the clock before
  // the first check so the monitor has noted the last accepted command
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly keys from a small pool so tunnels get modified, looked up and
  // torn down again; fresh keys only for misses and to hit a full table
  task automatic pick_random_command(output mode_t mode, output command_word_t c);
    int                sel;
    logic [ADDR_W-1:0] ue;
    logic [VER_W-1:0]  ver;
    logic [LEN_W-1:0]  tlen;
    sel = $urandom_range(0, 99);
    if (sel < 40)      mode = MODE_LOOKUP;
    else if (sel < 70) mode = MODE_MODIFY;
    else if (sel < 85) mode = MODE_DEL_USER;
    else               mode = MODE_DEL_CTRL;
    if (mode == MODE_MODIFY && sb.occupancy() == TABLE_ENTRIES && $urandom_range(0, 2) == 0)
      ue = $urandom;
    else if (mode != MODE_MODIFY && $urandom_range(0, 99) < 15)
      ue = $urandom;
    else
      ue = key_pool[$urandom_range(0, KEY_POOL - 1)];
    // mostly sane headers; the rest covers every version and short lengths
    ver  = ($urandom_range(0, 9) < 8) ? IP_VERSION_V4 : VER_W'($urandom_range(0, 15));
    tlen = ($urandom_range(0, 9) < 9) ? LEN_W'($urandom_range(20, 65535))
                                      : LEN_W'($urandom_range(0, 19));
    c = make_command(ue, $urandom, $urandom, $urandom, ver, tlen, LEN_W'($urandom));
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] ue;
    logic [ADDR_W-1:0] ones;
    ue   = 32'h0a00_0001;
    ones = '1;
    // header checks come before the table search
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, 4'd0, 16'd20, 16'd100));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, 4'd15, 16'hffff, 16'd100));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'd19, 16'd100));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, MIN_IP_TOTAL_LEN, 16'd1));
    // deletes on an empty table
    send_command(MODE_DEL_USER, make_command(ue, 0, 0, 0, 0, 0, 0));
    send_command(MODE_DEL_CTRL, make_command(ue, 0, 0, 0, 0, 0, 0));
    // full tunnel with all-ones fields, forwarded at both length extremes
    send_command(MODE_MODIFY, make_command(ue, ones, ones, ones, 0, 0, 0));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'hffff, 16'hffff));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'd20, 16'd0));
    // drop the control part: user tunnel without control tunnel
    send_command(MODE_DEL_CTRL, make_command(ue, 0, 0, 0, 0, 0, 0));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'd40, 16'd40));
    send_command(MODE_DEL_CTRL, make_command(ue, 0, 0, 0, 0, 0, 0));
    // modify restores both parts, then drop the user part: notify and queue
    send_command(MODE_MODIFY, make_command(ue, 0, 0, 0, 0, 0, 0));
    send_command(MODE_DEL_USER, make_command(ue, 0, 0, 0, 0, 0, 0));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'd40, 16'd40));
    send_command(MODE_DEL_USER, make_command(ue, 0, 0, 0, 0, 0, 0));
    // clearing the last part frees the entry
    send_command(MODE_DEL_CTRL, make_command(ue, 0, 0, 0, 0, 0, 0));
    send_command(MODE_LOOKUP, make_command(ue, 0, 0, 0, IP_VERSION_V4, 16'd40, 16'd40));
    // key extremes
    send_command(MODE_MODIFY, make_command('0, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f,
                                           0, 0, 0));
    send_command(MODE_MODIFY, make_command(ones, 32'hc0a8_0001, 32'h0000_0001, 32'h8000_0000,
                                           0, 0, 0));
    send_command(MODE_LOOKUP, make_command('0, 0, 0, 0, IP_VERSION_V4, 16'd1500, 16'd1480));
    send_command(MODE_LOOKUP, make_command(ones, 0, 0, 0, IP_VERSION_V4, 16'd1500, 16'd1480));
  endtask

  initial begin
    mode_t         mode;
    command_word_t c;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_LOOKUP;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain_results();

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 2) drain_results();
      pick_random_command(mode, c);
      send_command(mode, c);
    end

    // let the pipeline empty, then a few cycles for stray results
    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d commands and %0d results checked, table ended with %0d of %0d entries used",
             sb.commands, sb.results, sb.occupancy(), TABLE_ENTRIES);
    $display("verdicts unk %0d fwd %0d ntf %0d noctl %0d bhdr %0d ok %0d nf %0d full %0d",
             sb.verdict_seen[V_UNKNOWN], sb.verdict_seen[V_FORWARD], sb.verdict_seen[V_NOTIFY],
             sb.verdict_seen[V_NOCTRL], sb.verdict_seen[V_BADHDR], sb.verdict_seen[V_OK],
             sb.verdict_seen[V_NOTFOUND], sb.verdict_seen[V_FULL]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
